>>> design/flg_pkg.sv
// ----------------------------------------------------------------------------
// flg_pkg
// Shared types and codes for the modulated delay flanger.
// ----------------------------------------------------------------------------
package flg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COS_W    = 17;
    localparam int OFF_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COS_W-1:0]    cos_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY = 3'd0,
        CFG_DEPTH = 3'd1,
        CFG_STEP  = 3'd2,
        CFG_GAIN  = 3'd3,
        CFG_FRAME = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROM,
        ST_OFFSET,
        ST_WRAP,
        ST_GAIN,
        ST_OUT
    } flg_state_t;

endpackage

>>> design/flg_in_if.sv
// ----------------------------------------------------------------------------
// flg_in_if
// Input sample channel: valid/ready handshake, one sample per beat.
// ----------------------------------------------------------------------------
interface flg_in_if
    import flg_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

>>> design/flg_out_if.sv
// ----------------------------------------------------------------------------
// flg_out_if
// Output sample channel: valid/ready handshake, one sample per beat.
// ----------------------------------------------------------------------------
interface flg_out_if
    import flg_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

>>> design/modulated_delay_flanger.sv
// ----------------------------------------------------------------------------
// modulated_delay_flanger
// Flanger on a mono Q1.15 stream with a cosine-modulated delay tap.
// ----------------------------------------------------------------------------
// Each input beat yields one output beat. The sample sequencer walks cosine
// ROM read, offset multiply, delay-line wrap (repeated while the offset is at
// or above DELAY_DEPTH, never when DELAY_DEPTH >= 1023), the single delay-line
// read port and the gain multiply in turn, then waits out any output stall.
// The next sample can be taken in the cycle after the result is registered,
// so no new sample is taken before the last one is through. A finished result
// waits in the output register while the next sample is already accepted.
// The delay line is not cleared after reset; the reads whose data reach the
// output (inside the effect window) only reach written entries.
// ----------------------------------------------------------------------------
module modulated_delay_flanger
    import flg_pkg::*;
#(
    parameter int DELAY_DEPTH    = 1024,
    parameter int COS_TABLE_SIZE = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    flg_in_if.sink                in_ch,
    flg_out_if.source             out_ch
);

    localparam int PTR_W = $clog2(DELAY_DEPTH);
    localparam int IDX_W = $clog2(COS_TABLE_SIZE);

    flg_state_t state_reg, state_next;

    logic [8:0]  delay_reg;
    logic [8:0]  depth_reg;
    logic [31:0] step_reg;
    logic [14:0] gain_reg;
    logic [31:0] frame_reg;

    logic [31:0]      sidx_reg;
    logic [31:0]      phase_reg;
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wp_reg;
    logic [IDX_W-1:0] idx_reg;
    sample_t          x_reg;
    logic             win_reg;
    logic [OFF_W-1:0] back_reg;
    logic signed [30:0] prod_reg;
    logic             out_valid_reg;
    sample_t          out_sample_reg;

    logic               in_beat;
    logic               out_free;
    logic [8:0]         dmin;
    logic [9:0]         lo;
    logic               win_w;
    logic [32+IDX_W:0]  ip_w;
    cos_t               cos_q;
    logic signed [27:0] t_w;
    logic               wrap_more;
    logic [PTR_W:0]     rd_sum;
    logic [PTR_W-1:0]   rd_w;
    sample_t            mem_q;
    logic signed [30:0] scaled_w;
    logic signed [18:0] sum_w;
    sample_t            sat_w;

    assign in_beat  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign dmin  = (depth_reg < delay_reg) ? depth_reg : delay_reg;
    assign lo    = {1'b0, delay_reg} + {1'b0, dmin};
    assign win_w = (sidx_reg >= 32'(lo)) &&
                   (({1'b0, sidx_reg} + 33'(lo)) < {1'b0, frame_reg});

    assign ip_w = (33 + IDX_W)'(phase_reg) * (33 + IDX_W)'(COS_TABLE_SIZE);

    assign t_w = $signed({19'd0, dmin}) * 28'(cos_q)
               + $signed({4'd0, delay_reg, 15'd0});

    assign wrap_more = 32'(back_reg) >= DELAY_DEPTH;
    assign rd_sum    = {1'b0, wp_reg} + (PTR_W + 1)'(DELAY_DEPTH)
                     - (PTR_W + 1)'(back_reg);
    assign rd_w      = (rd_sum >= (PTR_W + 1)'(DELAY_DEPTH))
                     ? PTR_W'(rd_sum - (PTR_W + 1)'(DELAY_DEPTH))
                     : PTR_W'(rd_sum);

    assign scaled_w = prod_reg >>> 14;
    assign sum_w    = 19'(x_reg) + 19'(scaled_w);
    assign sat_w    = (sum_w > 19'sd32767)  ? 16'sh7FFF :
                      (sum_w < -19'sd32768) ? 16'sh8000 : SAMPLE_W'(sum_w);

    flg_cos_rom #(
        .COS_TABLE_SIZE (COS_TABLE_SIZE)
    ) u_rom (
        .clk  (clk),
        .addr (idx_reg),
        .data (cos_q)
    );

    flg_delay_mem #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (in_beat),
        .waddr (wptr_reg),
        .wdata (in_ch.sample_in),
        .raddr (rd_w),
        .rdata (mem_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        in_ch.ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM:    state_next = ST_OFFSET;
            ST_OFFSET: state_next = ST_WRAP;
            ST_WRAP:
            begin
                if (!wrap_more)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= 9'd441;
            depth_reg <= 9'd441;
            step_reg  <= 32'd4294967;
            gain_reg  <= 15'd16384;
            frame_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DELAY: delay_reg <= cfg_data[8:0];
                CFG_DEPTH: depth_reg <= cfg_data[8:0];
                CFG_STEP:  step_reg  <= cfg_data;
                CFG_GAIN:  gain_reg  <= cfg_data[14:0];
                CFG_FRAME: frame_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sidx_reg  <= '0;
            phase_reg <= '0;
            wptr_reg  <= '0;
        end
        else if (in_beat)
        begin
            sidx_reg  <= sidx_reg + 32'd1;
            phase_reg <= phase_reg + step_reg;
            wptr_reg  <= (wptr_reg == PTR_W'(DELAY_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            x_reg   <= in_ch.sample_in;
            win_reg <= win_w;
            wp_reg  <= wptr_reg;
            idx_reg <= ip_w[31+IDX_W:32];
        end
        if (state_reg == ST_OFFSET)
        begin
            back_reg <= t_w[24:15];
        end
        else if (state_reg == ST_WRAP && wrap_more)
        begin
            back_reg <= back_reg - OFF_W'(DELAY_DEPTH);
        end
        if (state_reg == ST_GAIN)
        begin
            prod_reg <= 31'(mem_q) * $signed({16'd0, gain_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_sample_reg <= win_reg ? sat_w : x_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;

endmodule

>>> design/flg_cos_rom.sv
// ----------------------------------------------------------------------------
// flg_cos_rom
// Full-wave cosine ROM, Q15 entries built at elaboration, registered read.
// ----------------------------------------------------------------------------
module flg_cos_rom
    import flg_pkg::*;
#(
    parameter int COS_TABLE_SIZE = 1024
)
(
    input  logic                              clk,
    input  logic [$clog2(COS_TABLE_SIZE)-1:0] addr,
    output cos_t                              data
);

    typedef cos_t rom_arr_t [COS_TABLE_SIZE];

    // cos(pi/2 * r / 2^30), Q30, even polynomial in r^2
    function automatic logic signed [63:0] cos_quarter(logic signed [63:0] r);
        logic signed [63:0] z;
        logic signed [63:0] p;
        z = (r * r) >>> 30;
        p = 64'sd27060;
        p = 64'sd987048 - ((p * z) >>> 30);
        p = 64'sd22401992 - ((p * z) >>> 30);
        p = 64'sd272375560 - ((p * z) >>> 30);
        p = 64'sd1324675879 - ((p * z) >>> 30);
        p = (64'sd1 <<< 30) - ((p * z) >>> 30);
        if (p < 0)
        begin
            p = 64'sd0;
        end
        return p;
    endfunction

    function automatic cos_t rom_entry(int unsigned k);
        logic [63:0]        q;
        logic [1:0]         quad;
        logic signed [63:0] r;
        logic signed [63:0] s;
        logic signed [63:0] v;
        logic signed [63:0] m;
        q    = (64'(k) << 32) / 64'(COS_TABLE_SIZE);
        quad = q[31:30];
        r    = $signed({34'd0, q[29:0]});
        s    = (64'sd1 <<< 30) - r;
        v    = (quad == 2'd0 || quad == 2'd2) ? cos_quarter(r) : cos_quarter(s);
        m    = (v + 64'sd16384) >>> 15;
        if (m > 64'sd32768)
        begin
            m = 64'sd32768;
        end
        return (quad == 2'd1 || quad == 2'd2) ? COS_W'(-m) : COS_W'(m);
    endfunction

    function automatic rom_arr_t build_rom();
        rom_arr_t t;
        for (int k = 0; k < COS_TABLE_SIZE; k++)
        begin
            t[k] = rom_entry(k);
        end
        return t;
    endfunction

    localparam rom_arr_t ROM = build_rom();

    always_ff @(posedge clk)
    begin
        data <= ROM[addr];
    end

endmodule

>>> design/flg_delay_mem.sv
// ----------------------------------------------------------------------------
// flg_delay_mem
// Circular delay line storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module flg_delay_mem
    import flg_pkg::*;
#(
    parameter int DELAY_DEPTH = 1024
)
(
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(DELAY_DEPTH)-1:0] waddr,
    input  sample_t                        wdata,
    input  logic [$clog2(DELAY_DEPTH)-1:0] raddr,
    output sample_t                        rdata
);

    sample_t mem [DELAY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/flg_checker.sv
// ----------------------------------------------------------------------------
// flg_checker
// Port-level checks on the flanger: beat accounting and output handshake.
// ----------------------------------------------------------------------------
module flg_checker
    import flg_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t sample_out
);

    logic [1:0] pend_reg;
    logic       in_b;
    logic       out_b;

    assign in_b  = in_valid && in_ready;
    assign out_b = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_b} - {1'b0, out_b};
        end
    end

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("output beat with no sample outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two samples outstanding");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_b |=> !in_ready)
        else $error("input taken while previous sample still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("stalled output beat dropped or changed");

endmodule

bind modulated_delay_flanger flg_checker u_flg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out)
);

>>> sim/tb_modulated_delay_flanger.sv
// ----------------------------------------------------------------------------
// tb_modulated_delay_flanger
// Self-checking bench for the modulated delay flanger. A queue-fed driver
// sends samples with random idle bursts, and a monitor takes output beats
// under random backpressure. Each output beat is checked against a bit-exact
// predictor. The predictor keeps its own cosine table, delay line, sample
// counter, phase accumulator and register copies. The run starts with a short
// directed part: field extremes, zero offset, depth above delay and
// saturation. It then goes through random register settings with random
// audio, and ends with a final stretch where neither side idles.
// ----------------------------------------------------------------------------
module tb_modulated_delay_flanger;
    timeunit 1ns;
    timeprecision 1ps;

    import flg_pkg::*;

    localparam int LINE_DEPTH     = 1024;
    localparam int LUT_SIZE       = 1024;
    localparam int PTR_W          = $clog2(LINE_DEPTH);
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 11;
    localparam int PHASE_ITEMS    = 140;
    localparam int MAX_REPORTS    = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    flg_in_if  in_ch ();
    flg_out_if out_ch ();

    modulated_delay_flanger #(
        .DELAY_DEPTH    (LINE_DEPTH),
        .COS_TABLE_SIZE (LUT_SIZE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // register shadow, reset values
    logic [8:0]  reg_delay = 9'd441;
    logic [8:0]  reg_depth = 9'd441;
    logic [31:0] reg_step  = 32'd4294967;
    logic [14:0] reg_gain  = 15'd16384;
    logic [31:0] reg_frame = 32'd0;

    // predictor state
    int          cos_lut [LUT_SIZE];
    sample_t     echo_line [LINE_DEPTH];
    logic [PTR_W-1:0] tap_wr       = '0;
    logic [31:0] sample_count = '0;
    logic [31:0] lfo_acc      = '0;

    sample_t stimulus_samples [$];
    sample_t expected_samples [$];

    int sent_beats    = 0;
    int checked_beats = 0;
    int mismatches    = 0;
    int window_hits   = 0;
    int clipped_hits  = 0;
    int setting_count = 0;
    int idle_pct      = 0;
    int in_gap        = 0;
    int out_gap       = 0;
    int quiet_cycles  = 0;
    bit in_sent       = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint quarter_cos(longint r);
        longint z;
        longint p;
        z = (r * r) >>> 30;
        p = 27060;
        p = 987048 - ((p * z) >>> 30);
        p = 22401992 - ((p * z) >>> 30);
        p = 272375560 - ((p * z) >>> 30);
        p = 1324675879 - ((p * z) >>> 30);
        p = (longint'(1) << 30) - ((p * z) >>> 30);
        if (p < 0)
            p = 0;
        return p;
    endfunction

    function automatic sample_t flange_sample(sample_t x);
        longint unsigned d;
        longint unsigned lo;
        longint          t;
        longint          prod;
        longint          sum;
        int unsigned     back;
        logic [PTR_W-1:0] rd_ptr;
        sample_t         y;
        d  = (reg_depth < reg_delay) ? reg_depth : reg_delay;
        lo = reg_delay + d;
        y  = x;
        echo_line[tap_wr] = x;
        if (longint'(sample_count) >= lo && longint'(sample_count) + lo < longint'(reg_frame))
        begin
            t    = longint'(d) * longint'(cos_lut[lfo_acc[31:22]])
                   + (longint'(reg_delay) << 15);
            back = int'((t >>> 15) % LINE_DEPTH);
            rd_ptr = PTR_W'((int'(tap_wr) + LINE_DEPTH - back) % LINE_DEPTH);
            prod = longint'(echo_line[rd_ptr]) * longint'(reg_gain);
            sum  = longint'(x) + (prod >>> 14);
            window_hits++;
            if (sum > 32767 || sum < -32768)
                clipped_hits++;
            if (sum > 32767)
                sum = 32767;
            if (sum < -32768)
                sum = -32768;
            y = sample_t'(sum);
        end
        tap_wr       = tap_wr + 1'b1;
        sample_count = sample_count + 1;
        lfo_acc      = lfo_acc + reg_step;
        return y;
    endfunction

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_DELAY: reg_delay = value[8:0];
            CFG_DEPTH: reg_depth = value[8:0];
            CFG_STEP:  reg_step  = value;
            CFG_GAIN:  reg_gain  = value[14:0];
            CFG_FRAME: reg_frame = value;
            default: ;
        endcase
    endtask

    task automatic drain_block;
        while (stimulus_samples.size() != 0 || expected_samples.size() != 0 || in_ch.valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [8:0] delay_v, input logic [8:0] depth_v,
                                  input logic [31:0] step_v, input logic [14:0] gain_v,
                                  input logic [31:0] frame_v);
        drain_block();
        set_reg(CFG_DELAY, ($urandom() << 9) | 32'(delay_v));
        set_reg(CFG_DEPTH, ($urandom() << 9) | 32'(depth_v));
        set_reg(CFG_STEP, step_v);
        set_reg(CFG_GAIN, ($urandom() << 15) | 32'(gain_v));
        set_reg(CFG_FRAME, frame_v);
        // unmapped index, must be ignored
        set_reg(CFG_IDX_W'(CFG_FRAME + 1 + $urandom_range(0, 2)), $urandom());
        @(negedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0:       return sample_t'(16'h7FFF);
            1:       return sample_t'(16'h8000);
            2:       return sample_t'($urandom_range(0, 511) - 256);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // input driver
    always @(negedge clk) begin
        if (rst_n && (!in_ch.valid || in_sent)) begin
            in_sent = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (stimulus_samples.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                in_gap = $urandom_range(0, 8);
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.valid     <= 1'b1;
                in_ch.sample_in <= stimulus_samples.pop_front();
            end
        end
    end

    // output backpressure
    always @(negedge clk) begin
        if (out_gap > 0) begin
            out_gap--;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            out_gap = $urandom_range(0, 8);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // prediction, checking and watchdog
    always @(posedge clk) begin
        sample_t want;
        bit      beat;
        beat = 1'b0;
        if (rst_n && in_ch.valid && in_ch.ready) begin
            expected_samples.push_back(flange_sample(in_ch.sample_in));
            in_sent = 1'b1;
            sent_beats++;
            beat = 1'b1;
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            beat = 1'b1;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("output beat %0d with nothing expected: got %0d",
                             checked_beats, out_ch.sample_out);
            end else begin
                want = expected_samples.pop_front();
                if (out_ch.sample_out !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("sample_out mismatch at beat %0d: expected %0d, got %0d",
                                 checked_beats, want, out_ch.sample_out);
                end
            end
            checked_beats++;
        end
        quiet_cycles = beat ? 0 : quiet_cycles + 1;
        if (rst_n && quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_modulated_delay_flanger: errors");
            $finish;
        end
    end

    initial begin
        longint      q;
        longint      r;
        longint      v;
        longint      m;
        logic [1:0]  quad;
        logic [8:0]  delay_v;
        logic [8:0]  depth_v;
        logic [31:0] step_v;
        logic [31:0] frame_v;
        logic [14:0] gain_v;
        int          lo;

        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        out_ch.ready    = 1'b0;
        rst_n           = 1'b0;

        for (int k = 0; k < LUT_SIZE; k++) begin
            q    = (longint'(k) << 32) / LUT_SIZE;
            quad = q[31:30];
            r    = q & 64'h3FFF_FFFF;
            v    = (quad == 2'd0 || quad == 2'd2) ? quarter_cos(r)
                                                  : quarter_cos((longint'(1) << 30) - r);
            m    = (v + 16384) >>> 15;
            if (m > 32768)
                m = 32768;
            cos_lut[k] = (quad == 2'd1 || quad == 2'd2) ? -int'(m) : int'(m);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, short clip so samples pass through
        idle_pct = 20;
        stimulus_samples.push_back(sample_t'(16'h7FFF));
        stimulus_samples.push_back(sample_t'(16'h8000));
        stimulus_samples.push_back(sample_t'(16'h0000));
        stimulus_samples.push_back(sample_t'(16'hFFFF));

        // zero offset, full gain, saturation both ways
        apply_settings(9'd0, 9'd0, 32'hFFFF_FFFF, 15'h7FFF, 32'hFFFF_FFFF);
        stimulus_samples.push_back(sample_t'(16'h7FFF));
        stimulus_samples.push_back(sample_t'(16'h8000));
        stimulus_samples.push_back(sample_t'(16'h0000));
        stimulus_samples.push_back(sample_t'(16'hFFFF));
        stimulus_samples.push_back(sample_t'(16'h0001));
        stimulus_samples.push_back(sample_t'(16'h4000));
        stimulus_samples.push_back(sample_t'(16'hC000));
        stimulus_samples.push_back(sample_t'(16'h5555));
        stimulus_samples.push_back(sample_t'(16'hAAAA));
        stimulus_samples.push_back(sample_t'(16'h3039));

        // depth above delay, quarter turn per sample
        apply_settings(9'd3, 9'd511, 32'h4000_0000, 15'd16384, 32'hFFFF_FFFF);
        for (int k = 0; k < 10; k++)
            stimulus_samples.push_back(random_sample());

        for (int p = 0; p < NUM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       delay_v = 9'd0;
                1:       delay_v = 9'd511;
                default: delay_v = 9'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       depth_v = 9'd0;
                1:       depth_v = 9'd511;
                default: depth_v = 9'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       step_v = 32'd0;
                1:       step_v = 32'hFFFF_FFFF;
                2:       step_v = $urandom_range(32'h0010_0000, 32'h0100_0000);
                default: step_v = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0:       gain_v = 15'd0;
                1:       gain_v = 15'h7FFF;
                2:       gain_v = 15'd16384;
                default: gain_v = 15'($urandom());
            endcase
            lo = int'(delay_v) + int'((depth_v < delay_v) ? depth_v : delay_v);
            // window end is placed relative to the settled sample count
            drain_block();
            case ($urandom_range(0, 5))
                0:       frame_v = 32'd0;
                1:       frame_v = 32'(2 * lo);
                2:       frame_v = sample_count + 32'(lo) + $urandom_range(20, PHASE_ITEMS);
                3:       frame_v = $urandom();
                default: frame_v = 32'hFFFF_FFFF;
            endcase
            apply_settings(delay_v, depth_v, step_v, gain_v, frame_v);
            if (p == NUM_PHASES - 1)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                stimulus_samples.push_back(random_sample());
        end

        drain_block();
        if (expected_samples.size() != 0) begin
            $display("%0d expected samples never came out", expected_samples.size());
            mismatches += expected_samples.size();
        end
        $display("%0d samples in, %0d out checked across %0d register settings",
                 sent_beats, checked_beats, setting_count);
        $display("%0d samples inside the effect window, %0d of them clipped",
                 window_hits, clipped_hits);
        if (mismatches == 0)
            $display("tb_modulated_delay_flanger: clean");
        else
            $display("tb_modulated_delay_flanger: errors");
        $finish;
    end

endmodule

>>> files.f
design/flg_pkg.sv
design/flg_in_if.sv
design/flg_out_if.sv
design/flg_cos_rom.sv
design/flg_delay_mem.sv
design/modulated_delay_flanger.sv
design/flg_checker.sv
sim/tb_modulated_delay_flanger.sv
